/* rtl/lpmd_pkg.sv */
// shared types and constants for the length-prefixed message deframer
// no dependencies
`default_nettype none

package lpmd_pkg;

    // width of the internal length and remaining-byte counter
    localparam int LENGTH_BITS = 24;

    localparam int MAX_LEN_W   = 24;
    localparam int CMP_W       = 32;
    localparam int HDR_BYTES   = 8;
    localparam int HDR_W       = HDR_BYTES * 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // configuration register indexes
    localparam logic [1:0] CFG_SIZE_CODE  = 2'd0;
    localparam logic [1:0] CFG_MAX_LEN    = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN = 2'd2;

    typedef struct packed {
        logic [1:0]           size_code;
        logic [MAX_LEN_W-1:0] max_len;
        logic                 big_endian;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_BODY,
        JOB_HEADER,
        JOB_ERROR
    } job_kind_t;

    // one queued piece of work for the output side
    typedef struct packed {
        job_kind_t        kind;
        logic [HDR_W-1:0] data;
        logic [1:0]       size_code;
        logic             mend;
    } job_t;

endpackage

`default_nettype wire

/* rtl/lpmd_front.sv */
// input side: header collection, length check and body counting
// depends on lpmd_pkg
`default_nettype none

module lpmd_front
    import lpmd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    input  wire logic       queue_full,
    input  wire logic       action,
    input  wire logic [7:0] byte_value,
    output logic            push,
    output job_t            push_job
);

    logic [HDR_W-1:0]       header_store_reg, header_store_next;
    logic [3:0]             header_count_reg, header_count_next;
    logic [LENGTH_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic                   in_body_reg, in_body_next;

    logic                   accept;
    logic [3:0]             hsize;
    logic [3:0]             count_inc;
    logic [HDR_W-1:0]       store_ins;
    logic [HDR_W-1:0]       len;
    logic [LENGTH_BITS-1:0] len_lo;
    logic                   len_hi_nz;
    logic                   sign_bit;
    logic                   len_bad;
    logic                   header_only;

    assign accept    = in_valid && !queue_full;
    assign hsize     = 4'd1 << cfg.size_code;
    assign count_inc = header_count_reg + 4'd1;

    // byte insertion and length assembly in either byte order
    always_comb
    begin
        store_ins = header_store_reg;
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            if ((header_count_reg == 4'(i)) && (header_count_reg < hsize))
            begin
                store_ins[i*8 +: 8] = byte_value;
            end
        end
        len = '0;
        for (int k = 0; k < HDR_BYTES; k++)
        begin
            if (4'(k) < hsize)
            begin
                if (cfg.big_endian)
                begin
                    len[k*8 +: 8] = store_ins[3'(hsize - 4'd1 - 4'(k))*8 +: 8];
                end
                else
                begin
                    len[k*8 +: 8] = store_ins[k*8 +: 8];
                end
            end
        end
    end

    always_comb
    begin
        unique case (cfg.size_code)
            2'd0:    sign_bit = len[7];
            2'd1:    sign_bit = len[15];
            2'd2:    sign_bit = len[31];
            default: sign_bit = len[63];
        endcase
    end

    assign len_lo      = len[LENGTH_BITS-1:0];
    assign len_hi_nz   = |len[HDR_W-1:LENGTH_BITS];
    assign len_bad     = sign_bit || len_hi_nz
                      || (len_lo < LENGTH_BITS'(hsize))
                      || (CMP_W'(len_lo) > CMP_W'(cfg.max_len));
    assign header_only = (len_lo == LENGTH_BITS'(hsize));

    always_comb
    begin
        header_store_next = header_store_reg;
        header_count_next = header_count_reg;
        bytes_left_next   = bytes_left_reg;
        in_body_next      = in_body_reg;
        push              = 1'b0;
        push_job.kind      = JOB_BODY;
        push_job.data      = {{(HDR_W-8){1'b0}}, byte_value};
        push_job.size_code = cfg.size_code;
        push_job.mend      = 1'b0;
        if (accept)
        begin
            if (action)
            begin
                header_store_next = '0;
                header_count_next = '0;
                bytes_left_next   = '0;
                in_body_next      = 1'b0;
            end
            else if (in_body_reg)
            begin
                push            = 1'b1;
                push_job.mend   = (bytes_left_reg == LENGTH_BITS'(1));
                bytes_left_next = bytes_left_reg - LENGTH_BITS'(1);
                in_body_next    = (bytes_left_reg != LENGTH_BITS'(1));
            end
            else if (count_inc < hsize)
            begin
                header_store_next = store_ins;
                header_count_next = count_inc;
            end
            else
            begin
                // header complete
                push              = 1'b1;
                header_store_next = '0;
                header_count_next = '0;
                if (len_bad)
                begin
                    push_job.kind   = JOB_ERROR;
                    bytes_left_next = '0;
                    in_body_next    = 1'b0;
                end
                else
                begin
                    push_job.kind   = JOB_HEADER;
                    push_job.data   = store_ins;
                    push_job.mend   = header_only;
                    bytes_left_next = len_lo - LENGTH_BITS'(hsize);
                    in_body_next    = !header_only;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_store_reg <= '0;
            header_count_reg <= '0;
            bytes_left_reg   <= '0;
            in_body_reg      <= 1'b0;
        end
        else
        begin
            header_store_reg <= header_store_next;
            header_count_reg <= header_count_next;
            bytes_left_reg   <= bytes_left_next;
            in_body_reg      <= in_body_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/lpmd_queue.sv */
// short job queue between the input and output sides
// depends on lpmd_pkg
`default_nettype none

module lpmd_queue
    import lpmd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output logic      full,
    output logic      not_empty,
    output job_t      head
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/lpmd_back.sv */
// output side: expands queued jobs into result transfers
// depends on lpmd_pkg
`default_nettype none

module lpmd_back
    import lpmd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  job_valid,
    input  wire job_t  job,
    output logic       pop,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic [7:0] data_byte,
    output logic       message_end,
    output logic       framing_error,
    output logic       run_end
);

    job_t       job_reg, job_next;
    logic       busy_reg, busy_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] data_reg, data_next;
    logic       mend_reg, mend_next;
    logic       ferr_reg, ferr_next;
    logic       rend_reg, rend_next;

    logic       can_load;
    logic       emit;
    logic       last;
    logic [2:0] last_idx;

    assign can_load = !out_valid_reg || !out_stall;
    assign emit     = busy_reg && can_load;
    assign last_idx = 3'((4'd1 << job_reg.size_code) - 4'd1);
    assign last     = (job_reg.kind != JOB_HEADER) || (idx_reg == last_idx);
    assign pop      = job_valid && (!busy_reg || (emit && last));

    always_comb
    begin
        job_next  = job_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            job_next  = job;
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (emit && last)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        data_next      = data_reg;
        mend_next      = mend_reg;
        ferr_next      = ferr_reg;
        rend_next      = rend_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            unique case (job_reg.kind)
                JOB_BODY:
                begin
                    data_next = job_reg.data[7:0];
                    mend_next = job_reg.mend;
                    ferr_next = 1'b0;
                    rend_next = 1'b1;
                end
                JOB_HEADER:
                begin
                    data_next = job_reg.data[idx_reg*8 +: 8];
                    mend_next = last && job_reg.mend;
                    ferr_next = 1'b0;
                    rend_next = last;
                end
                default:
                begin
                    data_next = 8'd0;
                    mend_next = 1'b0;
                    ferr_next = 1'b1;
                    rend_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        data_reg <= data_next;
        mend_reg <= mend_next;
        ferr_reg <= ferr_next;
        rend_reg <= rend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_byte     = data_reg;
    assign message_end   = mend_reg;
    assign framing_error = ferr_reg;
    assign run_end       = rend_reg;

endmodule

`default_nettype wire

/* rtl/length_prefixed_message_deframer.sv */
// length-prefixed message deframer, top level: config registers and the three stages
// path: a taken byte is written into the job queue, then into the back job register, then into the output register
// throughput: one byte in and one result out per cycle while in_stall and out_stall are low; a header
// releases 1, 2, 4 or 8 results, one per cycle, so the four-entry queue can fill and the input can
// stall after an 8-byte or a 4-byte header
// reset: asynchronous active low, clears framing, queue and output valid; config 2-byte le, 4096
`default_nettype none

module length_prefixed_message_deframer
    import lpmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // config write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [MAX_LEN_W-1:0] cfg_data,
    // input byte channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 action,
    input  wire logic [7:0]           byte_value,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                data_byte,
    output logic                      message_end,
    output logic                      framing_error,
    output logic                      run_end
);

    cfg_t cfg_reg, cfg_next;

    logic queue_full;
    logic queue_not_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head_job;

    // config writes are always accepted and take effect in the next cycle
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIZE_CODE:  cfg_next.size_code  = cfg_data[1:0];
                CFG_MAX_LEN:    cfg_next.max_len    = cfg_data;
                CFG_BIG_ENDIAN: cfg_next.big_endian = cfg_data[0];
                default:        cfg_next = cfg_reg;  // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_code  <= 2'd1;
            cfg_reg.max_len    <= MAX_LEN_W'(4096);
            cfg_reg.big_endian <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // the input side holds off only when the job queue is full
    assign in_stall = queue_full;

    // front: header collection, length check, body counting
    lpmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .queue_full (queue_full),
        .action     (action),
        .byte_value (byte_value),
        .push       (push),
        .push_job   (push_job)
    );

    // decouples header bursts from the byte rate
    lpmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_job)
    );

    // back: one result per cycle into the output register while out_stall allows it
    lpmd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (queue_not_empty),
        .job           (head_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_byte     (data_byte),
        .message_end   (message_end),
        .framing_error (framing_error),
        .run_end       (run_end)
    );

endmodule

`default_nettype wire
